// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define DPTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define DPTT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/dptt_pkg.sv -----
// Types and constants for the depth-preferred transposition table.
package dptt_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int MOVE_BITS_DEF  = 32;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_BOUND = 2'd1;
  localparam logic [1:0] KIND_SCORE = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] BOUND_UPPER = 2'd2;
  localparam logic [1:0] BOUND_LOWER = 2'd3;
  localparam logic [2:0] EMPTY_MARK  = 3'd4;

  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] CODE_CUT   = 3'd1;
  localparam logic [2:0] CODE_UPPER = 3'd2;
  localparam logic [2:0] CODE_LOWER = 3'd3;
  localparam logic [2:0] CODE_SORT  = 3'd4;

  localparam logic [16:0] FILL_MAX  = 17'h1FFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        position_key;
    logic [31:0]        best_move;
    logic signed [7:0]  search_depth;
    logic signed [15:0] entry_score;
    logic [1:0]         bound_type;
    logic signed [15:0] alpha_limit;
    logic signed [15:0] beta_limit;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic [15:0]        slot_index;
    logic [2:0]         probe_code;
    logic [31:0]        found_move;
    logic signed [15:0] found_score;
    logic signed [7:0]  found_depth;
    logic [1:0]         found_bound;
    logic [16:0]        fill_count;
    logic [31:0]        collision_count;
    logic [31:0]        reject_count;
  } out_word_t;

endpackage

// ----- design/depth_preferred_transposition_table_unit.sv -----
// Depth-preferred transposition table: entry memories, read-modify-write control, counters.
// Store and probe words: accepted in the idle state, result word registered in the exec state
// once the output is free; no new word before then, one read-then-write pass over the memories.
// Clear word: walks every slot, one per cycle, then gives its result word once the output is free.
// Reset: a pass over every slot zeroes keys and empties each slot; in_ready stays low.
// The input side takes a new word while an earlier result still waits on the output.
module depth_preferred_transposition_table_unit #(
  parameter int INDEX_BITS = dptt_pkg::INDEX_BITS_DEF,
  parameter int MOVE_BITS  = dptt_pkg::MOVE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dptt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dptt_pkg::out_word_t out_word
);
  import dptt_pkg::*;

  localparam int SLOTS = 1 << INDEX_BITS;

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  typedef struct packed {
    logic [63:0]          key;
    logic [MOVE_BITS-1:0] move;
    logic signed [15:0]   score;
  } data_ent_t;

  typedef struct packed {
    logic signed [7:0] depth;
    logic [2:0]        bound;
  } meta_ent_t;

  data_ent_t mem_data_r [SLOTS];
  meta_ent_t mem_meta_r [SLOTS];

  logic [1:0]            state_r, state_nxt;
  logic [INDEX_BITS-1:0] sweep_r, sweep_nxt;
  logic [16:0]           fill_r, fill_nxt;
  logic [31:0]           coll_r, coll_nxt;
  logic [31:0]           rej_r, rej_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;
  in_word_t              item_r;
  data_ent_t             rd_data_r;
  meta_ent_t             rd_meta_r;

  logic                  rd_en;
  logic                  data_we, meta_we;
  logic [INDEX_BITS-1:0] wr_addr;
  data_ent_t             data_wdata;
  meta_ent_t             meta_wdata;
  meta_ent_t             empty_meta;

  logic [INDEX_BITS-1:0] item_slot;
  logic                  out_free;
  logic                  occupied, key_eq, match, deeper;
  logic                  store_take, fill_inc, coll_inc, rej_inc;
  logic [16:0]           fill_step;
  logic [31:0]           coll_step, rej_step;
  out_word_t             res;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign item_slot  = item_r.position_key[INDEX_BITS-1:0];
  assign out_free   = !out_valid_r || out_ready;
  assign empty_meta = '{depth: -8'sd1, bound: EMPTY_MARK};

  assign occupied   = (rd_meta_r.bound != EMPTY_MARK);
  assign key_eq     = (rd_data_r.key == item_r.position_key);
  assign match      = occupied && key_eq;
  assign deeper     = (item_r.search_depth > rd_meta_r.depth);
  assign store_take = (item_r.kind == KIND_STORE) && deeper;
  assign fill_inc   = store_take && !occupied;
  assign coll_inc   = store_take && occupied && !key_eq;
  assign rej_inc    = (item_r.kind == KIND_STORE) && !deeper && !key_eq;

  assign fill_step = (fill_inc && fill_r != FILL_MAX) ? fill_r + 17'd1 : fill_r;
  assign coll_step = (coll_inc && coll_r != COUNT_MAX) ? coll_r + 32'd1 : coll_r;
  assign rej_step  = (rej_inc && rej_r != COUNT_MAX) ? rej_r + 32'd1 : rej_r;

  always_comb begin
    res                 = '0;
    res.accepted        = store_take;
    res.slot_index      = 16'(item_slot);
    res.fill_count      = fill_step;
    res.collision_count = coll_step;
    res.reject_count    = rej_step;
    if ((item_r.kind == KIND_BOUND || item_r.kind == KIND_SCORE) && match) begin
      res.found_move  = 32'(rd_data_r.move);
      res.found_depth = rd_meta_r.depth;
      res.found_bound = rd_meta_r.bound[1:0];
      if (item_r.kind == KIND_BOUND) begin
        res.found_score = rd_data_r.score;
        if (rd_meta_r.depth >= item_r.search_depth) begin
          case (rd_meta_r.bound[1:0])
            BOUND_UPPER: begin
              res.probe_code = (rd_data_r.score <= item_r.alpha_limit) ? CODE_CUT : CODE_UPPER;
            end
            BOUND_LOWER: begin
              res.probe_code = (rd_data_r.score >= item_r.beta_limit) ? CODE_CUT : CODE_LOWER;
            end
            default: begin
              res.probe_code = CODE_CUT;
            end
          endcase
        end else begin
          res.probe_code = CODE_SORT;
        end
      end else begin
        res.found_score = (rd_meta_r.depth == item_r.search_depth) ? rd_data_r.score : 16'sd0;
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    sweep_nxt        = sweep_r;
    fill_nxt         = fill_r;
    coll_nxt         = coll_r;
    rej_nxt          = rej_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_word_nxt     = out_word_r;
    rd_en            = 1'b0;
    data_we          = 1'b0;
    meta_we          = 1'b0;
    wr_addr          = item_slot;
    data_wdata.key   = item_r.position_key;
    data_wdata.move  = item_r.best_move[MOVE_BITS-1:0];
    data_wdata.score = item_r.entry_score;
    meta_wdata.depth = item_r.search_depth;
    meta_wdata.bound = {1'b0, item_r.bound_type};
    case (state_r)
      ST_INIT: begin
        data_we    = 1'b1;
        meta_we    = 1'b1;
        wr_addr    = sweep_r;
        data_wdata = '0;
        meta_wdata = empty_meta;
        sweep_nxt  = sweep_r + 1'b1;
        if (&sweep_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = (in_word.kind == KIND_CLEAR) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          data_we       = store_take;
          meta_we       = store_take;
          fill_nxt      = fill_step;
          coll_nxt      = coll_step;
          rej_nxt       = rej_step;
          out_valid_nxt = 1'b1;
          out_word_nxt  = res;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        meta_we    = 1'b1;
        wr_addr    = sweep_r;
        meta_wdata = empty_meta;
        if (!(&sweep_r)) begin
          sweep_nxt = sweep_r + 1'b1;
        end else if (out_free) begin
          sweep_nxt     = sweep_r + 1'b1;
          fill_nxt      = '0;
          coll_nxt      = '0;
          rej_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      mem_data_r[wr_addr] <= data_wdata;
    end
    if (meta_we) begin
      mem_meta_r[wr_addr] <= meta_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem_data_r[in_word.position_key[INDEX_BITS-1:0]];
      rd_meta_r <= mem_meta_r[in_word.position_key[INDEX_BITS-1:0]];
      item_r    <= in_word;
    end
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      fill_r      <= '0;
      coll_r      <= '0;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      fill_r      <= fill_nxt;
      coll_r      <= coll_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/dptt_checker.sv -----
// Port-level checks for the transposition table and their bind to the top level.
`include "assert_macros.svh"

module dptt_checker #(
  parameter int INDEX_BITS = dptt_pkg::INDEX_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dptt_pkg::out_word_t out_word
);
  import dptt_pkg::*;

  localparam longint SLOTS = longint'(1) << INDEX_BITS;

  logic store_shown;
  logic probe_blank;

  assign store_shown = out_valid && out_word.accepted;
  assign probe_blank = (out_word.probe_code == CODE_NONE) && (out_word.found_move == 32'd0);

  `DPTT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_ready, "busy after reset")
  `DPTT_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second word taken")
  `DPTT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "word moved")
  `DPTT_ASSERT(a_fill_bound, out_valid |-> longint'(out_word.fill_count) <= SLOTS, "fill too high")
  `DPTT_ASSERT(a_store_no_probe, store_shown |-> probe_blank, "written store reports probe data")

endmodule

bind depth_preferred_transposition_table_unit dptt_checker #(.INDEX_BITS(INDEX_BITS)) u_dptt_checker (.*);

// ----- tb/dptt_result_monitor.sv -----
// Result monitor: predicts each transposition-table result word and compares it with the block.
module dptt_result_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dptt_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dptt_pkg::out_word_t out_word,
  output int                  mismatch_count,
  output int                  pending_count
);
  import dptt_pkg::*;

  localparam int SLOT_BITS = INDEX_BITS_DEF;
  localparam int SLOTS = 1 << SLOT_BITS;
  localparam logic [31:0] MOVE_KEEP = 32'hFFFF_FFFF >> (32 - MOVE_BITS_DEF);

  logic [63:0]        key_mem   [SLOTS];
  logic [31:0]        move_mem  [SLOTS];
  logic signed [7:0]  depth_mem [SLOTS];
  logic signed [15:0] score_mem [SLOTS];
  logic [2:0]         bound_mem [SLOTS];
  logic [16:0]        fills;
  logic [31:0]        collisions;
  logic [31:0]        rejects;

  out_word_t reply_q[$];
  int        errors = 0;

  function automatic void wipe_slots();
    for (int i = 0; i < SLOTS; i++) begin
      depth_mem[i] = -8'sd1;
      bound_mem[i] = EMPTY_MARK;
    end
    fills = '0;
    collisions = '0;
    rejects = '0;
  endfunction

  function automatic out_word_t table_access(in_word_t w);
    out_word_t              r;
    logic [SLOT_BITS-1:0]   slot;
    logic                   occupied;
    logic                   hit;
    int                     depth;
    int                     sd;
    int                     ss;
    int                     alpha;
    int                     beta;
    r = '0;
    slot = w.position_key[SLOT_BITS-1:0];
    occupied = bound_mem[slot] != EMPTY_MARK;
    hit = occupied && key_mem[slot] == w.position_key;
    depth = $signed(w.search_depth);
    sd = $signed(depth_mem[slot]);
    ss = $signed(score_mem[slot]);
    alpha = $signed(w.alpha_limit);
    beta = $signed(w.beta_limit);
    r.slot_index = 16'(slot);
    case (w.kind)
      KIND_STORE: begin
        if (depth > sd) begin
          if (!occupied) begin
            if (fills != FILL_MAX) fills = fills + 1'b1;
          end else if (key_mem[slot] != w.position_key) begin
            if (collisions != COUNT_MAX) collisions = collisions + 1'b1;
          end
          key_mem[slot] = w.position_key;
          move_mem[slot] = w.best_move & MOVE_KEEP;
          depth_mem[slot] = w.search_depth;
          score_mem[slot] = w.entry_score;
          bound_mem[slot] = {1'b0, w.bound_type};
          r.accepted = 1'b1;
        end else if (key_mem[slot] != w.position_key) begin
          if (rejects != COUNT_MAX) rejects = rejects + 1'b1;
        end
      end
      KIND_CLEAR: begin
        wipe_slots();
        r.slot_index = '0;
      end
      default: begin
        if (hit) begin
          r.found_move = move_mem[slot];
          r.found_depth = depth_mem[slot];
          r.found_bound = bound_mem[slot][1:0];
          if (w.kind == KIND_BOUND) begin
            r.found_score = score_mem[slot];
            if (sd >= depth) begin
              case (bound_mem[slot][1:0])
                BOUND_UPPER: r.probe_code = (ss <= alpha) ? CODE_CUT : CODE_UPPER;
                BOUND_LOWER: r.probe_code = (ss >= beta) ? CODE_CUT : CODE_LOWER;
                default:     r.probe_code = CODE_CUT;
              endcase
            end else begin
              r.probe_code = CODE_SORT;
            end
          end else begin
            r.found_score = (sd == depth) ? score_mem[slot] : '0;
          end
        end
      end
    endcase
    r.fill_count = fills;
    r.collision_count = collisions;
    r.reject_count = rejects;
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) key_mem[i] = '0;
      wipe_slots();
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t result word with nothing outstanding: %h", $time, out_word);
        end else begin
          want = reply_q.pop_front();
          check_field("accepted", want.accepted, out_word.accepted);
          check_field("slot_index", want.slot_index, out_word.slot_index);
          check_field("probe_code", want.probe_code, out_word.probe_code);
          check_field("found_move", want.found_move, out_word.found_move);
          check_field("found_score", want.found_score, out_word.found_score);
          check_field("found_depth", want.found_depth, out_word.found_depth);
          check_field("found_bound", want.found_bound, out_word.found_bound);
          check_field("fill_count", want.fill_count, out_word.fill_count);
          check_field("collision_count", want.collision_count, out_word.collision_count);
          check_field("reject_count", want.reject_count, out_word.reject_count);
        end
      end
      if (in_valid && in_ready) reply_q.push_back(table_access(in_word));
    end
    mismatch_count <= errors;
    pending_count <= reply_q.size();
  end

endmodule

// ----- tb/tb_depth_preferred_transposition_table_unit.sv -----
// Testbench top: drives directed and random table words under varied flow control, gives the verdict.
module tb_depth_preferred_transposition_table_unit;
  import dptt_pkg::*;

  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0]  BOUND_LEAF  = 2'd0;
  localparam logic [1:0]  BOUND_EXACT = 2'd1;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          POOL_KEYS   = 24;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int holds_done = 0;
  int hold_left = 0;
  int clears_left = 3;

  logic [63:0]       key_pool   [POOL_KEYS];
  logic signed [7:0] pool_depth [POOL_KEYS];

  always #10 clk = ~clk;

  depth_preferred_transposition_table_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  dptt_result_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_request) begin
      holds_done <= hold_request;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("depth_preferred_transposition_table_unit verification failed");
    $finish;
  end

  function automatic in_word_t make_word(logic [1:0] kind, logic [63:0] key, logic [31:0] move,
                                         int depth, int score, logic [1:0] bound,
                                         int alpha, int beta);
    in_word_t w;
    w.kind = kind;
    w.position_key = key;
    w.best_move = move;
    w.search_depth = 8'(depth);
    w.entry_score = 16'(score);
    w.bound_type = bound;
    w.alpha_limit = 16'(alpha);
    w.beta_limit = 16'(beta);
    return w;
  endfunction

  function automatic void refresh_pool(bit with_edges);
    logic [15:0] slot;
    for (int s = 0; s < POOL_KEYS / 3; s++) begin
      slot = 16'($urandom);
      if (with_edges && s == 0) slot = 16'h0000;
      if (with_edges && s == 1) slot = 16'hFFFF;
      for (int k = 0; k < 3; k++) begin
        key_pool[s * 3 + k] = {$urandom, 16'($urandom), slot};
        pool_depth[s * 3 + k] = '0;
      end
    end
  endfunction

  function automatic logic [15:0] window_value();
    return ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(600) - 300);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    int       r;
    pick = -1;
    r = $urandom_range(299);
    if (r == 0 && clears_left > 0) begin
      w.kind = KIND_CLEAR;
      clears_left--;
    end else if (r < 135) begin
      w.kind = KIND_STORE;
    end else if (r < 225) begin
      w.kind = KIND_BOUND;
    end else begin
      w.kind = KIND_SCORE;
    end
    if ($urandom_range(6) == 0) begin
      w.position_key = {$urandom, $urandom};
    end else begin
      pick = $urandom_range(POOL_KEYS - 1);
      w.position_key = key_pool[pick];
    end
    w.best_move = $urandom;
    w.search_depth = ($urandom_range(6) == 0) ? 8'($urandom) : 8'($urandom_range(15) - 2);
    w.entry_score = window_value();
    w.bound_type = 2'($urandom);
    w.alpha_limit = window_value();
    w.beta_limit = window_value();
    if (pick >= 0) begin
      if (w.kind == KIND_STORE) pool_depth[pick] = w.search_depth;
      else if (w.kind == KIND_SCORE && $urandom_range(1) == 1) w.search_depth = pool_depth[pick];
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (idle_pct != 0) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic await_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t directed[$];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    refresh_pool(1'b1);

    directed.push_back(make_word(KIND_BOUND, 64'h0, 32'h0, 0, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h0, 32'h0, -1, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h1_0000, 32'h1, -128, 5, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h1_0000, 32'hFFFF_FFFF, 0, 0, BOUND_UPPER,
                                 0, 0));
    directed.push_back(make_word(KIND_BOUND, 64'h1_0000, 32'h0, 0, 0, BOUND_LEAF, 0, 32767));
    directed.push_back(make_word(KIND_BOUND, 64'h1_0000, 32'h0, 0, 0, BOUND_LEAF, -1, 32767));
    directed.push_back(make_word(KIND_BOUND, 64'h1_0000, 32'h0, 1, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, ALL_ONES, 32'h0, 127, 32767, BOUND_LOWER, 0, 0));
    directed.push_back(make_word(KIND_BOUND, ALL_ONES, 32'h0, 127, 0, BOUND_LEAF,
                                 -32768, 32767));
    directed.push_back(make_word(KIND_STORE, 64'h5, 32'h1234_5678, 3, 100, BOUND_LOWER, 0, 0));
    directed.push_back(make_word(KIND_BOUND, 64'h5, 32'h0, 3, 0, BOUND_LEAF, 0, 101));
    directed.push_back(make_word(KIND_STORE, ALL_ONES, 32'h9, 127, 1, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 32'h9, 127, 1,
                                 BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_SCORE, ALL_ONES, 32'h0, 127, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_SCORE, ALL_ONES, 32'h0, 126, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h2_0000, 32'hA5A5_5A5A, 5, -7, BOUND_EXACT,
                                 0, 0));
    directed.push_back(make_word(KIND_BOUND, 64'h1_0000, 32'h0, 0, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_BOUND, 64'h2_0000, 32'h0, 5, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'hA, 32'hFFFF_FFFF, 2, -32768, BOUND_LEAF,
                                 0, 0));
    directed.push_back(make_word(KIND_BOUND, 64'hA, 32'h0, -128, 0, BOUND_LEAF, 32767, -32768));
    directed.push_back(make_word(KIND_CLEAR, ALL_ONES, 32'hFFFF_FFFF, -1, -1, BOUND_LOWER,
                                 -1, -1));
    directed.push_back(make_word(KIND_BOUND, 64'h2_0000, 32'h0, 0, 0, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h2_0000, 32'h3, -1, 3, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h3_0000, 32'h3, -1, 3, BOUND_LEAF, 0, 0));
    directed.push_back(make_word(KIND_STORE, 64'h2_0000, 32'h77, 0, 1234, BOUND_UPPER, 0, 0));
    directed.push_back(make_word(KIND_SCORE, 64'h2_0000, 32'h0, 0, 0, BOUND_LEAF, 0, 0));
    foreach (directed[i]) send_word(directed[i]);
    await_replies();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 86; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 86; end
        default: begin idle_pct = 31; stall_pct <= 31; end
      endcase
      for (int n = 0; n < 400; n++) begin
        if (n % 100 == 0) refresh_pool(1'b0);
        if (p == 0 && n == 50) hold_request <= hold_request + 1;
        send_word(random_word());
      end
      await_replies();
    end

    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("depth_preferred_transposition_table_unit verification clean");
    end else begin
      $display("depth_preferred_transposition_table_unit verification failed");
    end
    $finish;
  end

endmodule
